/* rtl/hkf_pkg.sv */
// shared types and constants for the keyboard hotkey filter
package hkf_pkg;

  localparam logic [15:0] EVT_KEY     = 16'd1;
  localparam logic [31:0] VAL_RELEASE = 32'd0;
  localparam logic [31:0] VAL_PRESS   = 32'd1;
  localparam logic [31:0] VAL_REPEAT  = 32'd2;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd400;

  // modifier group bits of needed_mods
  localparam int unsigned M_CTRL  = 0;
  localparam int unsigned M_ALT   = 1;
  localparam int unsigned M_SUPER = 2;
  localparam int unsigned M_SHIFT = 3;

  // key codes tracked in modifiers_held, one bit each
  localparam logic [15:0] MOD_CODES [8] = '{
    16'd29, 16'd97, 16'd56, 16'd100, 16'd125, 16'd126, 16'd42, 16'd54
  };

  typedef enum logic [1:0] {
    REG_COMBO_KEY   = 2'd0,
    REG_NEEDED_MODS = 2'd1,
    REG_DRY_RUN     = 2'd2,
    REG_DEBOUNCE_MS = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [9:0]  combo_key;
    logic [3:0]  needed_mods;
    logic        dry_run;
    logic [15:0] debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
    logic [31:0]        time_ms;
  } item_t;

  typedef struct packed {
    logic               forward_valid;
    logic [15:0]        out_type;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic               toggle_request;
  } result_t;

endpackage

/* rtl/keyboard_hotkey_filter_core.sv */
// top level of the keyboard hotkey filter: config, item register and result register
//
// One result item comes out for every input item; an item waits in the input register,
// where the hotkey decision and the filter state update are made, and then sits in the
// result register until taken. One item can be accepted every cycle while the result
// side keeps up. The filter state is updated in the same cycle as the decision, which
// sets the one-item-per-cycle rate. Configuration writes take effect on the next cycle;
// the user must make them only while the block is idle, as the block itself does not
// enforce it.
module keyboard_hotkey_filter_core
  import hkf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        event_type,
  input  logic [15:0]        event_code,
  input  logic signed [31:0] event_value,
  input  logic [31:0]        time_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               forward_valid,
  output logic [15:0]        out_type,
  output logic [15:0]        out_code,
  output logic signed [31:0] out_value,
  output logic               toggle_request
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  result_t res, result;
  logic    res_take, fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.combo_key   <= 10'd0;
      cfg.needed_mods <= 4'd0;
      cfg.dry_run     <= 1'b0;
      cfg.debounce_ms <= DEBOUNCE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        REG_COMBO_KEY:   cfg.combo_key   <= cfg_data[9:0];
        REG_NEEDED_MODS: cfg.needed_mods <= cfg_data[3:0];
        REG_DRY_RUN:     cfg.dry_run     <= cfg_data[0];
        REG_DEBOUNCE_MS: cfg.debounce_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register frees when empty or being taken
  assign res_take = !out_valid || out_ready;
  assign fire     = item_valid && res_take;
  assign in_ready = !item_valid || res_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.event_type  <= event_type;
      item.event_code  <= event_code;
      item.event_value <= event_value;
      item.time_ms     <= time_ms;
    end
  end

  hkf_filter u_filter (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item),
    .fire (fire),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res;
    end
  end

  assign forward_valid  = result.forward_valid;
  assign out_type       = result.out_type;
  assign out_code       = result.out_code;
  assign out_value      = result.out_value;
  assign toggle_request = result.toggle_request;

  // a held result is not overwritten while the consumer stalls
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(result)))
    else $error("result changed while stalled");

  // a pending item in the input register moves on as soon as the result side frees
  a_item_moves: assert property (@(posedge clk) disable iff (rst)
    (item_valid && res_take) |=> out_valid)
    else $error("item lost between stages");

  // an item that is not forwarded carries zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !forward_valid) |->
      (out_type == 16'd0 && out_code == 16'd0 && out_value == 32'sd0))
    else $error("payload on a swallowed item");

endmodule

/* rtl/hkf_filter.sv */
// hotkey decision logic and the filter state it keeps
module hkf_filter
  import hkf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    fire,
  output result_t res
);

  logic [7:0]  modifiers_held, modifiers_held_next;
  logic        swallow_release, swallow_release_next;
  logic [31:0] last_trigger_time, last_trigger_time_next;
  logic        has_triggered, has_triggered_next;

  logic        is_key, mods_ok, swallowed, forward, toggle;
  logic [31:0] elapsed;
  logic [31:0] value_u;

  assign value_u = item.event_value;
  assign elapsed = item.time_ms - last_trigger_time;

  always_comb begin
    mods_ok = 1'b1;
    if (cfg.needed_mods[M_CTRL]  && (modifiers_held[1:0] == 2'b00)) mods_ok = 1'b0;
    if (cfg.needed_mods[M_ALT]   && (modifiers_held[3:2] == 2'b00)) mods_ok = 1'b0;
    if (cfg.needed_mods[M_SUPER] && (modifiers_held[5:4] == 2'b00)) mods_ok = 1'b0;
    if (cfg.needed_mods[M_SHIFT] && (modifiers_held[7:6] == 2'b00)) mods_ok = 1'b0;
  end

  always_comb begin
    is_key                 = (item.event_type == EVT_KEY) && (value_u != VAL_REPEAT);
    swallowed              = 1'b0;
    toggle                 = 1'b0;
    modifiers_held_next    = modifiers_held;
    swallow_release_next   = swallow_release;
    last_trigger_time_next = last_trigger_time;
    has_triggered_next     = has_triggered;
    if (is_key) begin
      if (item.event_code == {6'd0, cfg.combo_key}) begin
        if (value_u == VAL_PRESS) begin
          if (mods_ok) begin
            swallowed = 1'b1;
            // first trigger after reset ignores the debounce window
            if (!has_triggered || (elapsed >= {16'd0, cfg.debounce_ms})) begin
              last_trigger_time_next = item.time_ms;
              has_triggered_next     = 1'b1;
              swallow_release_next   = 1'b1;
              toggle                 = 1'b1;
            end
          end else begin
            swallow_release_next = 1'b0;
          end
        end else if ((value_u == VAL_RELEASE) && swallow_release) begin
          swallow_release_next = 1'b0;
          swallowed            = 1'b1;
        end
      end
      if (!swallowed) begin
        for (int i = 0; i < 8; i++) begin
          if (item.event_code == MOD_CODES[i]) begin
            modifiers_held_next[i] = (value_u != VAL_RELEASE);
          end
        end
      end
    end
    forward = !swallowed && !cfg.dry_run;
  end

  always_comb begin
    res.forward_valid  = forward;
    res.out_type       = forward ? item.event_type  : 16'd0;
    res.out_code       = forward ? item.event_code  : 16'd0;
    res.out_value      = forward ? item.event_value : 32'sd0;
    res.toggle_request = toggle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modifiers_held    <= 8'd0;
      swallow_release   <= 1'b0;
      last_trigger_time <= 32'd0;
      has_triggered     <= 1'b0;
    end else if (fire) begin
      modifiers_held    <= modifiers_held_next;
      swallow_release   <= swallow_release_next;
      last_trigger_time <= last_trigger_time_next;
      has_triggered     <= has_triggered_next;
    end
  end

  // a toggle always swallows the press it came from
  a_toggle_swallows: assert property (@(posedge clk) disable iff (rst)
    res.toggle_request |-> !res.forward_valid)
    else $error("toggle raised on a forwarded item");

  // an accepted trigger leaves has_triggered set and arms the release swallow
  a_trigger_arms: assert property (@(posedge clk) disable iff (rst)
    (fire && res.toggle_request) |=> (has_triggered && swallow_release))
    else $error("trigger did not update filter state");

  // swallow_release only comes up on an accepted trigger
  a_swallow_source: assert property (@(posedge clk) disable iff (rst)
    $rose(swallow_release) |-> $past(fire && res.toggle_request))
    else $error("release swallow armed without a trigger");

endmodule
